@@ design/avrdt_pkg.sv @@
// ----------------------------------------------------------------------------
// avrdt_pkg: shared types and constants
// item layouts, instruction codes, memory geometry and controller handshake
// ----------------------------------------------------------------------------
package avrdt_pkg;

  // data memory depth, power of two from 256 to 65536
  localparam int MEM_DEPTH = 4096;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam logic [3:0] CMD_MOV  = 4'd0;
  localparam logic [3:0] CMD_MOVW = 4'd1;
  localparam logic [3:0] CMD_LDI  = 4'd2;
  localparam logic [3:0] CMD_LD   = 4'd3;
  localparam logic [3:0] CMD_LDD  = 4'd4;
  localparam logic [3:0] CMD_STS  = 4'd5;
  localparam logic [3:0] CMD_ST   = 4'd6;
  localparam logic [3:0] CMD_STD  = 4'd7;
  localparam logic [3:0] CMD_LPM  = 4'd8;
  localparam logic [3:0] CMD_ELPM = 4'd9;
  localparam logic [3:0] CMD_SPM  = 4'd10;
  localparam logic [3:0] CMD_XCH  = 4'd11;
  localparam logic [3:0] CMD_LAS  = 4'd12;
  localparam logic [3:0] CMD_LAC  = 4'd13;
  localparam logic [3:0] CMD_LAT  = 4'd14;
  // unassigned opcode, does nothing
  localparam logic [3:0] CMD_NONE = 4'd15;

  localparam logic [1:0] PTR_Z   = 2'd0;
  localparam logic [1:0] PTR_Y   = 2'd1;
  localparam logic [1:0] PTR_X   = 2'd2;
  localparam logic [1:0] PTR_BAD = 2'd3;

  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_INC    = 2'd1;
  localparam logic [1:0] MODE_DEC    = 2'd2;
  // unassigned mode, behaves as plain
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // low register of each pointer pair
  localparam logic [4:0] BASE_Z = 5'd30;
  localparam logic [4:0] BASE_Y = 5'd28;
  localparam logic [4:0] BASE_X = 5'd26;

  typedef struct packed {
    logic [3:0]  command;
    logic [4:0]  primary_reg;
    logic [4:0]  second_reg;
    logic [1:0]  pointer_select;
    logic [1:0]  addr_mode;
    logic [5:0]  displacement;
    logic [7:0]  immediate;
    logic [15:0] direct_address;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  reg_value;
    logic [15:0] pointer_value;
    logic        mem_written;
    logic [15:0] mem_address;
    logic [15:0] mem_value;
  } out_item_t;

  typedef struct packed {
    logic clr_we;
    logic capture;
    logic phase_a;
    logic phase_b;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/avrdt_ram.sv @@
// ----------------------------------------------------------------------------
// avrdt_ram: generic single-port-write ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module avrdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/avrdt_ctrl.sv @@
// ----------------------------------------------------------------------------
// avrdt_ctrl: instruction sequencer
// clears the memory after reset, then steps each item through address,
// data and commit phases
// ----------------------------------------------------------------------------
module avrdt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  avrdt_pkg::dp_status_t sts,
  output avrdt_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_ADDR   = 5'b00100,
    ST_DATA   = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.phase_a = 1'b1;
        state_nxt   = ST_DATA;
      end
      ST_DATA: begin
        cmd.phase_b = 1'b1;
        state_nxt   = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/avrdt_dp.sv @@
// ----------------------------------------------------------------------------
// avrdt_dp: transfer datapath
// register file, rampz, address generation, data memory and result register
// ----------------------------------------------------------------------------
module avrdt_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  avrdt_pkg::in_item_t   in_item,
  input  avrdt_pkg::ctl_cmd_t   cmd,
  output avrdt_pkg::dp_status_t sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output avrdt_pkg::out_item_t  out_item
);

  avrdt_pkg::in_item_t  it_r;
  avrdt_pkg::out_item_t out_r, res;
  logic                 out_valid_r;

  logic [7:0]  rf_r [32];
  logic [7:0]  rf_nxt [32];
  logic [7:0]  seg_r, seg_nxt;

  logic [23:0] ea_r, ea;
  logic [23:0] np_r, np;
  logic        pwr_r, pwr;
  logic [7:0]  ra_r, rb_r, md_r;
  logic [avrdt_pkg::MEM_AW-1:0] clr_cnt_r;

  logic [4:0]  base, base_hi, rsel;
  logic [15:0] p, z;
  logic        is_ptr_cmd, bad, is_rmw;
  logic [7:0]  nm;

  logic                         ram_we;
  logic [avrdt_pkg::MEM_AW-1:0] ram_waddr;
  logic [7:0]                   ram_wdata;
  logic [7:0]                   ram_rdata;

  // pointer pair selection
  always_comb begin
    is_ptr_cmd = 1'b0;
    case (it_r.command)
      avrdt_pkg::CMD_LD, avrdt_pkg::CMD_LDD,
      avrdt_pkg::CMD_ST, avrdt_pkg::CMD_STD: is_ptr_cmd = 1'b1;
      default: is_ptr_cmd = 1'b0;
    endcase
    base = avrdt_pkg::BASE_Z;
    if (is_ptr_cmd) begin
      case (it_r.pointer_select)
        avrdt_pkg::PTR_Y: base = avrdt_pkg::BASE_Y;
        avrdt_pkg::PTR_X: base = avrdt_pkg::BASE_X;
        default:          base = avrdt_pkg::BASE_Z;
      endcase
    end
    base_hi = {base[4:1], 1'b1};
    bad     = is_ptr_cmd && (it_r.pointer_select == avrdt_pkg::PTR_BAD);
    p       = {rf_r[base_hi], rf_r[base]};
    z       = {rf_r[avrdt_pkg::BASE_Z + 5'd1], rf_r[avrdt_pkg::BASE_Z]};
  end

  // effective address and updated pointer
  always_comb begin
    ea  = {8'd0, p};
    np  = {8'd0, p};
    pwr = 1'b0;
    case (it_r.command)
      avrdt_pkg::CMD_LDD, avrdt_pkg::CMD_STD: begin
        ea = {8'd0, p + {10'd0, it_r.displacement}};
      end
      avrdt_pkg::CMD_LD, avrdt_pkg::CMD_ST: begin
        if (it_r.addr_mode == avrdt_pkg::MODE_DEC) begin
          ea  = {8'd0, p - 16'd1};
          np  = ea;
          pwr = 1'b1;
        end else if (it_r.addr_mode == avrdt_pkg::MODE_INC) begin
          np  = {8'd0, p + 16'd1};
          pwr = 1'b1;
        end
      end
      avrdt_pkg::CMD_STS: ea = {8'd0, it_r.direct_address};
      avrdt_pkg::CMD_LPM: begin
        np  = {8'd0, z + 16'd1};
        pwr = (it_r.addr_mode == avrdt_pkg::MODE_INC);
      end
      avrdt_pkg::CMD_ELPM: begin
        ea  = {seg_r, z};
        np  = {seg_r, z} + 24'd1;
        pwr = (it_r.addr_mode == avrdt_pkg::MODE_INC);
      end
      avrdt_pkg::CMD_SPM: begin
        ea  = {seg_r, z};
        np  = {seg_r, z} + 24'd2;
        pwr = (it_r.addr_mode == avrdt_pkg::MODE_INC);
      end
      default: ea = {8'd0, p};
    endcase
  end

  // single register read port
  always_comb begin
    if (cmd.phase_b) begin
      rsel = {it_r.second_reg[3:0], 1'b1};
    end else if (it_r.command == avrdt_pkg::CMD_MOV) begin
      rsel = it_r.second_reg;
    end else if (it_r.command == avrdt_pkg::CMD_MOVW) begin
      rsel = {it_r.second_reg[3:0], 1'b0};
    end else begin
      rsel = it_r.primary_reg;
    end
  end

  always_comb begin
    is_rmw = 1'b0;
    nm     = ra_r;
    case (it_r.command)
      avrdt_pkg::CMD_XCH: begin is_rmw = 1'b1; nm = ra_r; end
      avrdt_pkg::CMD_LAS: begin is_rmw = 1'b1; nm = ra_r | md_r; end
      avrdt_pkg::CMD_LAC: begin is_rmw = 1'b1; nm = ~ra_r & md_r; end
      avrdt_pkg::CMD_LAT: begin is_rmw = 1'b1; nm = ra_r ^ md_r; end
      default: is_rmw = 1'b0;
    endcase
  end

  // register file update and result at commit
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      rf_nxt[i] = rf_r[i];
    end
    seg_nxt = seg_r;
    res     = '0;
    if (bad) begin
      res.status = 1'b1;
    end else begin
      case (it_r.command)
        avrdt_pkg::CMD_MOV: begin
          rf_nxt[it_r.primary_reg] = ra_r;
          res.reg_value = ra_r;
        end
        avrdt_pkg::CMD_MOVW: begin
          rf_nxt[{it_r.primary_reg[3:0], 1'b0}] = ra_r;
          rf_nxt[{it_r.primary_reg[3:0], 1'b1}] = rb_r;
          res.reg_value = ra_r;
        end
        avrdt_pkg::CMD_LDI: begin
          rf_nxt[{1'b1, it_r.primary_reg[3:0]}] = it_r.immediate;
          res.reg_value = it_r.immediate;
        end
        avrdt_pkg::CMD_LD, avrdt_pkg::CMD_LDD, avrdt_pkg::CMD_LPM,
        avrdt_pkg::CMD_ELPM, avrdt_pkg::CMD_XCH, avrdt_pkg::CMD_LAS,
        avrdt_pkg::CMD_LAC, avrdt_pkg::CMD_LAT: begin
          rf_nxt[it_r.primary_reg] = md_r;
          res.reg_value = md_r;
        end
        default: res.reg_value = 8'd0;
      endcase
      // pointer write-back wins over a loaded byte
      if (pwr_r) begin
        rf_nxt[base]    = np_r[7:0];
        rf_nxt[base_hi] = np_r[15:8];
        if (it_r.command == avrdt_pkg::CMD_ELPM || it_r.command == avrdt_pkg::CMD_SPM) begin
          seg_nxt = np_r[23:16];
        end
      end
      case (it_r.command)
        avrdt_pkg::CMD_LD, avrdt_pkg::CMD_LDD, avrdt_pkg::CMD_ST,
        avrdt_pkg::CMD_STD, avrdt_pkg::CMD_LPM, avrdt_pkg::CMD_ELPM,
        avrdt_pkg::CMD_SPM: begin
          res.pointer_value = {rf_nxt[base_hi], rf_nxt[base]};
        end
        avrdt_pkg::CMD_XCH, avrdt_pkg::CMD_LAS,
        avrdt_pkg::CMD_LAC, avrdt_pkg::CMD_LAT: begin
          res.pointer_value = ea_r[15:0];
        end
        default: res.pointer_value = 16'd0;
      endcase
      case (it_r.command)
        avrdt_pkg::CMD_ST, avrdt_pkg::CMD_STD, avrdt_pkg::CMD_STS: begin
          res.mem_written = 1'b1;
          res.mem_address = ea_r[15:0];
          res.mem_value   = {8'd0, ra_r};
        end
        avrdt_pkg::CMD_SPM: begin
          res.mem_written = 1'b1;
          res.mem_address = ea_r[15:0];
          res.mem_value   = {rf_r[1], rf_r[0]};
        end
        avrdt_pkg::CMD_XCH, avrdt_pkg::CMD_LAS,
        avrdt_pkg::CMD_LAC, avrdt_pkg::CMD_LAT: begin
          res.mem_written = 1'b1;
          res.mem_address = ea_r[15:0];
          res.mem_value   = {8'd0, nm};
        end
        default: res.mem_written = 1'b0;
      endcase
    end
  end

  // memory write port: clearing sweep, spm low byte, commit write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ea_r[avrdt_pkg::MEM_AW-1:0];
    ram_wdata = res.mem_value[7:0];
    if (cmd.clr_we) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = 8'd0;
    end else if (cmd.phase_b && it_r.command == avrdt_pkg::CMD_SPM) begin
      ram_we    = 1'b1;
      ram_wdata = rf_r[0];
    end else if (cmd.commit && res.mem_written) begin
      ram_we = 1'b1;
      if (it_r.command == avrdt_pkg::CMD_SPM) begin
        ram_waddr = ea_r[avrdt_pkg::MEM_AW-1:0] + {{(avrdt_pkg::MEM_AW-1){1'b0}}, 1'b1};
        ram_wdata = rf_r[1];
      end
    end
  end

  avrdt_ram #(
    .WIDTH (8),
    .DEPTH (avrdt_pkg::MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ea[avrdt_pkg::MEM_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign sts.clr_done = &clr_cnt_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) it_r <= in_item;
    if (cmd.phase_a) begin
      ea_r  <= ea;
      np_r  <= np;
      pwr_r <= pwr;
      ra_r  <= rf_r[rsel];
    end
    if (cmd.phase_b) begin
      rb_r <= rf_r[rsel];
      md_r <= ram_rdata;
    end
    if (cmd.commit) out_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) begin
        rf_r[i] <= 8'd0;
      end
      seg_r       <= 8'd0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        for (int i = 0; i < 32; i++) begin
          rf_r[i] <= rf_nxt[i];
        end
        seg_r <= seg_nxt;
      end
      if (cmd.clr_we) clr_cnt_r <= clr_cnt_r + {{(avrdt_pkg::MEM_AW-1){1'b0}}, 1'b1};
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

@@ design/avr_data_transfer_unit.sv @@
// ----------------------------------------------------------------------------
// avr_data_transfer_unit: avr data-transfer instruction executor
// usage:
//   - in channel: one item per instruction (command, registers, pointer,
//     addressing mode, displacement, immediate, direct address), taken when
//     in_valid is high and in_stall is low
//   - out channel: exactly one result item per instruction, in order, held
//     in an output register while out_stall is high
//   - an item goes through accept, address phase (pointer math and
//     memory read issue), data phase (registered memory read, second register
//     byte, spm low byte write), commit (register file, rampz and memory
//     write, result load), in that order
//   - result appears on out_valid the cycle after commit; the next item is
//     not accepted before that commit and can be taken in the cycle after it
//   - if the receiver stalls, the finished item waits in the output register;
//     the next item is still accepted and worked, and holds at commit
//     until the output register frees up
//   - reset clears the register file and rampz at once, then sweeps all
//     MEM_DEPTH bytes (4096) of the data memory to zero, one byte a cycle,
//     during which in_stall stays high
// ----------------------------------------------------------------------------
module avr_data_transfer_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  avrdt_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output avrdt_pkg::out_item_t out_item
);

  // controller to datapath commands and status
  avrdt_pkg::ctl_cmd_t   cmd;
  avrdt_pkg::dp_status_t sts;

  avrdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  avrdt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for avr_data_transfer_unit
// drives avr data-transfer instructions with random idling and stalls, keeps
// a software copy of registers, rampz and data memory to predict each result
// item, and checks every result item field by field in order
// ----------------------------------------------------------------------------
class xfer_scoreboard;
  // predicted architectural state
  logic [7:0] regs [32];
  logic [7:0] dmem [avrdt_pkg::MEM_DEPTH];
  logic [7:0] rampz;
  avrdt_pkg::out_item_t pending [$];
  int         mismatches;

  function new();
    foreach (regs[i]) regs[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    rampz = '0;
    mismatches = 0;
  endfunction

  function logic [15:0] pair(logic [4:0] lo);
    return {regs[5'(lo + 5'd1)], regs[lo]};
  endfunction

  function void set_pair(logic [4:0] lo, logic [15:0] w);
    regs[lo] = w[7:0];
    regs[5'(lo + 5'd1)] = w[15:8];
  endfunction

  function int widx(logic [31:0] a);
    return int'(a % avrdt_pkg::MEM_DEPTH);
  endfunction

  // apply one instruction to the predicted state and queue its result item
  function void note_instruction(avrdt_pkg::in_item_t it);
    avrdt_pkg::out_item_t r;
    logic [4:0] base;
    logic [15:0] p, w, ea;
    logic [23:0] la;
    logic [7:0] m, rd, nm;
    r = '0;
    case (it.command)
      avrdt_pkg::CMD_MOV: begin
        regs[it.primary_reg] = regs[it.second_reg];
        r.reg_value = regs[it.primary_reg];
      end
      avrdt_pkg::CMD_MOVW: begin
        w = pair({it.second_reg[3:0], 1'b0});
        set_pair({it.primary_reg[3:0], 1'b0}, w);
        r.reg_value = w[7:0];
      end
      avrdt_pkg::CMD_LDI: begin
        regs[{1'b1, it.primary_reg[3:0]}] = it.immediate;
        r.reg_value = it.immediate;
      end
      avrdt_pkg::CMD_LD, avrdt_pkg::CMD_LDD, avrdt_pkg::CMD_ST, avrdt_pkg::CMD_STD: begin
        if (it.pointer_select == avrdt_pkg::PTR_BAD) begin
          r.status = 1'b1;
        end else begin
          base = (it.pointer_select == avrdt_pkg::PTR_Z) ? avrdt_pkg::BASE_Z :
                 (it.pointer_select == avrdt_pkg::PTR_Y) ? avrdt_pkg::BASE_Y :
                                                           avrdt_pkg::BASE_X;
          p = pair(base);
          if (it.command == avrdt_pkg::CMD_LDD || it.command == avrdt_pkg::CMD_STD) begin
            ea = p + 16'(it.displacement);
            if (it.command == avrdt_pkg::CMD_LDD) begin
              regs[it.primary_reg] = dmem[widx(32'(ea))];
              r.reg_value = dmem[widx(32'(ea))];
            end else begin
              dmem[widx(32'(ea))] = regs[it.primary_reg];
              r.mem_written = 1'b1;
              r.mem_address = ea;
              r.mem_value = {8'h00, regs[it.primary_reg]};
            end
          end else begin
            if (it.addr_mode == avrdt_pkg::MODE_DEC) p = p - 16'd1;
            if (it.command == avrdt_pkg::CMD_LD) begin
              r.reg_value = dmem[widx(32'(p))];
              regs[it.primary_reg] = r.reg_value;
            end else begin
              r.mem_value = {8'h00, regs[it.primary_reg]};
              dmem[widx(32'(p))] = regs[it.primary_reg];
              r.mem_written = 1'b1;
              r.mem_address = p;
            end
            if (it.addr_mode == avrdt_pkg::MODE_INC) p = p + 16'd1;
            // write-back beats the loaded byte when the pointer is the target
            if (it.addr_mode == avrdt_pkg::MODE_INC || it.addr_mode == avrdt_pkg::MODE_DEC)
              set_pair(base, p);
          end
          r.pointer_value = pair(base);
        end
      end
      avrdt_pkg::CMD_STS: begin
        dmem[widx(32'(it.direct_address))] = regs[it.primary_reg];
        r.mem_written = 1'b1;
        r.mem_address = it.direct_address;
        r.mem_value = {8'h00, regs[it.primary_reg]};
      end
      avrdt_pkg::CMD_LPM: begin
        p = pair(avrdt_pkg::BASE_Z);
        regs[it.primary_reg] = dmem[widx(32'(p))];
        r.reg_value = dmem[widx(32'(p))];
        if (it.addr_mode == avrdt_pkg::MODE_INC) set_pair(avrdt_pkg::BASE_Z, p + 16'd1);
        r.pointer_value = pair(avrdt_pkg::BASE_Z);
      end
      avrdt_pkg::CMD_ELPM: begin
        la = {rampz, pair(avrdt_pkg::BASE_Z)};
        regs[it.primary_reg] = dmem[widx(32'(la))];
        r.reg_value = dmem[widx(32'(la))];
        if (it.addr_mode == avrdt_pkg::MODE_INC) begin
          la = la + 24'd1;
          set_pair(avrdt_pkg::BASE_Z, la[15:0]);
          rampz = la[23:16];
        end
        r.pointer_value = pair(avrdt_pkg::BASE_Z);
      end
      avrdt_pkg::CMD_SPM: begin
        la = {rampz, pair(avrdt_pkg::BASE_Z)};
        w = pair(5'd0);
        dmem[widx(32'(la))] = w[7:0];
        dmem[widx(32'(la) + 32'd1)] = w[15:8];
        r.mem_written = 1'b1;
        r.mem_address = la[15:0];
        r.mem_value = w;
        if (it.addr_mode == avrdt_pkg::MODE_INC) begin
          la = la + 24'd2;
          set_pair(avrdt_pkg::BASE_Z, la[15:0]);
          rampz = la[23:16];
        end
        r.pointer_value = pair(avrdt_pkg::BASE_Z);
      end
      avrdt_pkg::CMD_XCH, avrdt_pkg::CMD_LAS, avrdt_pkg::CMD_LAC, avrdt_pkg::CMD_LAT: begin
        p = pair(avrdt_pkg::BASE_Z);
        m = dmem[widx(32'(p))];
        rd = regs[it.primary_reg];
        case (it.command)
          avrdt_pkg::CMD_XCH: nm = rd;
          avrdt_pkg::CMD_LAS: nm = rd | m;
          avrdt_pkg::CMD_LAC: nm = ~rd & m;
          default: nm = rd ^ m;
        endcase
        dmem[widx(32'(p))] = nm;
        regs[it.primary_reg] = m;
        r.reg_value = m;
        r.mem_written = 1'b1;
        r.mem_address = p;
        r.mem_value = {8'h00, nm};
        r.pointer_value = p;
      end
      default: ;
    endcase
    pending.push_back(r);
  endfunction

  function void check_result(avrdt_pkg::out_item_t got);
    avrdt_pkg::out_item_t exp;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item %p", got);
      return;
    end
    exp = pending.pop_front();
    if (got.status !== exp.status || got.reg_value !== exp.reg_value ||
        got.pointer_value !== exp.pointer_value || got.mem_written !== exp.mem_written ||
        got.mem_address !== exp.mem_address || got.mem_value !== exp.mem_value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch at %0t: expected %p got %p", $realtime, exp, got);
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  avrdt_pkg::in_item_t  in_item;
  logic                 out_valid;
  logic                 out_stall;
  avrdt_pkg::out_item_t out_item;

  xfer_scoreboard sb;
  int  send_idle_pct;   // sender idle chance per cycle
  int  recv_stall_pct;  // receiver stall chance per cycle
  bit  hold_off;        // long receiver hold-off in progress
  longint cycles;

  avr_data_transfer_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: clearing sweep plus 446 slow items is far below this
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver: random stall, forced high during a hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result items are checked at the edge where they are taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  function automatic avrdt_pkg::in_item_t rand_item();
    avrdt_pkg::in_item_t it;
    it = avrdt_pkg::in_item_t'(48'({$urandom, $urandom}));
    it.command = 4'($urandom_range(14));
    if ($urandom_range(9) != 0) it.pointer_select = 2'($urandom_range(2));
    if ($urandom_range(9) != 0) it.addr_mode = 2'($urandom_range(2));
    // steer STS near used addresses often so loads see written data
    if ($urandom_range(1)) it.direct_address = 16'($urandom_range(63));
    return it;
  endfunction

  // offer one item and hold it until taken
  task automatic send(avrdt_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_instruction(it);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic avrdt_pkg::in_item_t mk(logic [3:0] c, logic [4:0] pr, logic [4:0] sr,
                                             logic [1:0] ps, logic [1:0] md);
    avrdt_pkg::in_item_t it;
    it = '0;
    it.command = c; it.primary_reg = pr; it.second_reg = sr;
    it.pointer_select = ps; it.addr_mode = md;
    return it;
  endfunction

  task automatic directed();
    avrdt_pkg::in_item_t it;
    it = mk(avrdt_pkg::CMD_LDI, 5'd31, 5'd0, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_PLAIN);
    it.immediate = 8'hFF; send(it);
    it = mk(avrdt_pkg::CMD_LDI, 5'd0, 5'd0, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_PLAIN);
    it.immediate = 8'hA5; send(it);
    it = mk(avrdt_pkg::CMD_LDI, 5'd14, 5'd0, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_PLAIN);
    it.immediate = 8'h00; send(it);
    send(mk(avrdt_pkg::CMD_MOV, 5'd0, 5'd16, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_PLAIN));
    send(mk(avrdt_pkg::CMD_MOVW, 5'd15, 5'd8, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_PLAIN));
    // Z = 0x00A5 then pre-decrement store and post-increment load into Z's low byte
    it = mk(avrdt_pkg::CMD_ST, 5'd0, 5'd0, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_DEC); send(it);
    send(mk(avrdt_pkg::CMD_LD, 5'd30, 5'd0, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_INC));
    send(mk(avrdt_pkg::CMD_ST, 5'd31, 5'd0, avrdt_pkg::PTR_X, avrdt_pkg::MODE_UNUSED));
    send(mk(avrdt_pkg::CMD_LD, 5'd1, 5'd0, avrdt_pkg::PTR_BAD, avrdt_pkg::MODE_INC));
    send(mk(avrdt_pkg::CMD_ST, 5'd1, 5'd0, avrdt_pkg::PTR_BAD, avrdt_pkg::MODE_PLAIN));
    it = mk(avrdt_pkg::CMD_LDD, 5'd2, 5'd0, avrdt_pkg::PTR_BAD, avrdt_pkg::MODE_PLAIN);
    send(it);
    it = mk(avrdt_pkg::CMD_STD, 5'd0, 5'd0, avrdt_pkg::PTR_X, avrdt_pkg::MODE_DEC);
    it.displacement = 6'd63; send(it);
    it = mk(avrdt_pkg::CMD_LDD, 5'd3, 5'd0, avrdt_pkg::PTR_Y, avrdt_pkg::MODE_INC);
    it.displacement = 6'd63; send(it);
    it = mk(avrdt_pkg::CMD_STS, 5'd0, 5'd0, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_PLAIN);
    it.direct_address = 16'hFFFF; send(it);
    it = mk(avrdt_pkg::CMD_LDI, 5'd15, 5'd0, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_PLAIN);
    it.immediate = 8'hFF; send(it);
    send(mk(avrdt_pkg::CMD_LPM, 5'd4, 5'd0, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_INC));
    send(mk(avrdt_pkg::CMD_ELPM, 5'd5, 5'd0, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_DEC));
    send(mk(avrdt_pkg::CMD_LDI, 5'd14, 5'd0, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_PLAIN));
    send(mk(avrdt_pkg::CMD_ELPM, 5'd6, 5'd0, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_INC));
    send(mk(avrdt_pkg::CMD_SPM, 5'd0, 5'd0, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_INC));
    send(mk(avrdt_pkg::CMD_SPM, 5'd0, 5'd0, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_UNUSED));
    send(mk(avrdt_pkg::CMD_XCH, 5'd7, 5'd0, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_PLAIN));
    send(mk(avrdt_pkg::CMD_LAS, 5'd0, 5'd0, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_PLAIN));
    send(mk(avrdt_pkg::CMD_LAC, 5'd16, 5'd0, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_PLAIN));
    send(mk(avrdt_pkg::CMD_LAT, 5'd31, 5'd0, avrdt_pkg::PTR_Z, avrdt_pkg::MODE_PLAIN));
    it = avrdt_pkg::in_item_t'(48'({$urandom, $urandom}));
    it.command = avrdt_pkg::CMD_NONE; send(it);
  endtask

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send(rand_item());
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    directed();
    random_phase(110, 0, 0);
    random_phase(110, 64, 0);
    random_phase(110, 0, 64);
    random_phase(80, 13, 13);

    // long hold-off on the result side while items keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_idle_pct = 0;
        repeat (10) send(rand_item());
      end
    join
    recv_stall_pct = 0;
    go_idle();

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ avr_data_transfer_unit.f @@
design/avrdt_pkg.sv
design/avrdt_ram.sv
design/avrdt_ctrl.sv
design/avrdt_dp.sv
design/avr_data_transfer_unit.sv
bench/tb.sv
